// ===== rtl/height_band_color_ramp_macros.svh =====
// Assertion macros shared by the height band color ramp RTL
`ifndef HEIGHT_BAND_COLOR_RAMP_MACROS_SVH
`define HEIGHT_BAND_COLOR_RAMP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HBCR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HBCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hbcr_pkg.sv =====
// Shared types, color tables and constants of the height band color ramp
`timescale 1ns / 1ps

package hbcr_pkg;

    localparam int LAND_BANDS = 5;

    // Band ends in hundredths of full scale
    localparam int unsigned END_HUND [LAND_BANDS] = '{40, 58, 72, 87, 100};

    localparam int unsigned SEA_RESET = 22938;

    // Channel positions inside rgb_t
    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    typedef enum logic [2:0] {
        CLS_OCEAN,
        CLS_BAND0,
        CLS_BAND1,
        CLS_BAND2,
        CLS_BAND3,
        CLS_BAND4,
        CLS_PEAK
    } band_t;

    // Beat tag carried alongside the data through every stage
    typedef struct packed {
        logic  valid;
        band_t cls;
    } tag_t;

    typedef logic [2:0][7:0] rgb_t;

    // Bright end of each ramp
    function automatic rgb_t color_start(band_t cls);
        rgb_t c;
        unique case (cls)
            CLS_OCEAN: c = {8'd40,  8'd95,  8'd195};
            CLS_BAND0: c = {8'd205, 8'd185, 8'd120};
            CLS_BAND1: c = {8'd100, 8'd178, 8'd62};
            CLS_BAND2: c = {8'd148, 8'd132, 8'd84};
            CLS_BAND3: c = {8'd132, 8'd122, 8'd116};
            CLS_BAND4: c = {8'd242, 8'd242, 8'd246};
            CLS_PEAK:  c = {8'd242, 8'd242, 8'd246};
            default:   c = '0;
        endcase
        return c;
    endfunction

    // Dark end of each ramp; the peak color is flat
    function automatic rgb_t color_end(band_t cls);
        rgb_t c;
        unique case (cls)
            CLS_OCEAN: c = {8'd10,  8'd30,  8'd90};
            CLS_BAND0: c = {8'd165, 8'd148, 8'd95};
            CLS_BAND1: c = {8'd55,  8'd120, 8'd30};
            CLS_BAND2: c = {8'd95,  8'd85,  8'd50};
            CLS_BAND3: c = {8'd85,  8'd78,  8'd74};
            CLS_BAND4: c = {8'd185, 8'd183, 8'd190};
            CLS_PEAK:  c = {8'd242, 8'd242, 8'd246};
            default:   c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/hbcr_classify.sv =====
// Band classification and offset/width computation, two register stages
`timescale 1ns / 1ps
`include "height_band_color_ramp_macros.svh"

module hbcr_classify #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [FRACTION_BITS+1:0] height,
    input  logic [FRACTION_BITS:0]        sea,
    output hbcr_pkg::tag_t                out_tag,
    output logic [FRACTION_BITS:0]        offset,
    output logic [FRACTION_BITS:0]        width
);

    localparam int F = FRACTION_BITS;
    localparam longint ONE_L = longint'(1) << F;

    localparam logic [F:0] BAND_END [hbcr_pkg::LAND_BANDS] = '{
        (F+1)'((longint'(hbcr_pkg::END_HUND[0]) * ONE_L + 50) / 100),
        (F+1)'((longint'(hbcr_pkg::END_HUND[1]) * ONE_L + 50) / 100),
        (F+1)'((longint'(hbcr_pkg::END_HUND[2]) * ONE_L + 50) / 100),
        (F+1)'((longint'(hbcr_pkg::END_HUND[3]) * ONE_L + 50) / 100),
        (F+1)'((longint'(hbcr_pkg::END_HUND[4]) * ONE_L + 50) / 100)
    };

    // Stage A: compares against sea level and every band end
    logic                  a_valid_reg;
    logic signed [F+2:0]   a_h_reg;
    logic [F:0]            a_sea_reg;
    logic                  a_lt_sea_reg;
    logic [hbcr_pkg::LAND_BANDS-1:0] a_le_end_reg;

    logic signed [F+2:0]   h_x;
    logic                  lt_sea_next;
    logic [hbcr_pkg::LAND_BANDS-1:0] le_end_next;

    always_comb
    begin
        h_x         = {height[F+1], height};
        lt_sea_next = h_x < $signed({2'b00, sea});
        for (int k = 0; k < hbcr_pkg::LAND_BANDS; k++)
        begin
            le_end_next[k] = h_x <= $signed({2'b00, BAND_END[k]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_h_reg      <= h_x;
        a_sea_reg    <= sea;
        a_lt_sea_reg <= lt_sea_next;
        a_le_end_reg <= le_end_next;
    end

    // Stage B: pick band start/end, subtract
    hbcr_pkg::band_t     cls_next;
    logic signed [F+2:0] prev_x;
    logic signed [F+2:0] end_x;
    logic signed [F+2:0] off_x;
    logic signed [F+2:0] w_x;
    logic                zero;
    logic [F:0]          offset_next;
    logic [F:0]          width_next;

    always_comb
    begin
        priority if (a_lt_sea_reg)
        begin
            cls_next = hbcr_pkg::CLS_OCEAN;
            prev_x   = '0;
            end_x    = {2'b00, a_sea_reg};
        end
        else if (a_le_end_reg[0])
        begin
            cls_next = hbcr_pkg::CLS_BAND0;
            prev_x   = {2'b00, a_sea_reg};
            end_x    = {2'b00, BAND_END[0]};
        end
        else if (a_le_end_reg[1])
        begin
            cls_next = hbcr_pkg::CLS_BAND1;
            prev_x   = {2'b00, BAND_END[0]};
            end_x    = {2'b00, BAND_END[1]};
        end
        else if (a_le_end_reg[2])
        begin
            cls_next = hbcr_pkg::CLS_BAND2;
            prev_x   = {2'b00, BAND_END[1]};
            end_x    = {2'b00, BAND_END[2]};
        end
        else if (a_le_end_reg[3])
        begin
            cls_next = hbcr_pkg::CLS_BAND3;
            prev_x   = {2'b00, BAND_END[2]};
            end_x    = {2'b00, BAND_END[3]};
        end
        else if (a_le_end_reg[4])
        begin
            cls_next = hbcr_pkg::CLS_BAND4;
            prev_x   = {2'b00, BAND_END[3]};
            end_x    = {2'b00, BAND_END[4]};
        end
        else
        begin
            cls_next = hbcr_pkg::CLS_PEAK;
            prev_x   = '0;
            end_x    = '0;
        end

        off_x = a_h_reg - prev_x;
        w_x   = end_x - prev_x;
        // Peak, empty band or non-positive offset: force t to zero via 0 / 1
        zero  = (cls_next == hbcr_pkg::CLS_PEAK) || (off_x <= 0) || (w_x <= 0);

        offset_next = zero ? '0 : off_x[F:0];
        width_next  = zero ? (F+1)'(1) : w_x[F:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_tag <= '0;
        end
        else
        begin
            out_tag.valid <= a_valid_reg;
            out_tag.cls   <= cls_next;
        end
    end

    always_ff @(posedge clk)
    begin
        offset <= offset_next;
        width  <= width_next;
    end

    `HBCR_ASSERT_IMPLIES(a_offset_in_range, clk, rst_n, out_tag.valid, offset <= width, "offset exceeds band width")

endmodule

// ===== rtl/hbcr_div.sv =====
// Pipelined restoring divider for the ramp fraction, up to two quotient bits per stage
`timescale 1ns / 1ps
`include "height_band_color_ramp_macros.svh"

module hbcr_div #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hbcr_pkg::tag_t         in_tag,
    input  logic [FRACTION_BITS:0] offset,
    input  logic [FRACTION_BITS:0] width,
    output hbcr_pkg::tag_t         out_tag,
    output logic [FRACTION_BITS:0] t
);

    localparam int F      = FRACTION_BITS;
    localparam int R_W    = F + 2;
    localparam int STAGES = (F + 2) / 2;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    hbcr_pkg::tag_t  tag_in  [STAGES];
    logic [R_W-1:0]  rem_in  [STAGES];
    logic [F:0]      den_in  [STAGES];
    logic [F:0]      quo_in  [STAGES];

    hbcr_pkg::tag_t  tag_reg [STAGES];
    logic [R_W-1:0]  rem_reg [STAGES];
    logic [F:0]      den_reg [STAGES];
    logic [F:0]      quo_reg [STAGES];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        logic [R_W-1:0] r;
        logic [F:0]     q;

        if (g == 0)
        begin : g_first
            // Offset never exceeds width, so the top quotient bit is bit F
            assign tag_in[g] = in_tag;
            assign rem_in[g] = {1'b0, offset};
            assign den_in[g] = width;
            assign quo_in[g] = '0;
        end
        else
        begin : g_next
            assign tag_in[g] = tag_reg[g-1];
            assign rem_in[g] = rem_reg[g-1];
            assign den_in[g] = den_reg[g-1];
            assign quo_in[g] = quo_reg[g-1];
        end

        always_comb
        begin
            r = rem_in[g];
            q = quo_in[g];
            for (int s = 0; s < 2; s++)
            begin
                if (2 * g + s <= F)
                begin
                    if (2 * g + s != 0)
                    begin
                        r = r << 1;
                    end
                    if (r >= {1'b0, den_in[g]})
                    begin
                        r = r - {1'b0, den_in[g]};
                        q = {q[F-1:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[F-1:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[g] <= '0;
            end
            else
            begin
                tag_reg[g] <= tag_in[g];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g] <= r;
            den_reg[g] <= den_in[g];
            quo_reg[g] <= q;
        end
    end

    assign out_tag = tag_reg[STAGES-1];
    assign t       = quo_reg[STAGES-1];

    `HBCR_ASSERT_IMPLIES(a_fraction_max, clk, rst_n, out_tag.valid, t <= ONE, "fraction above one")

endmodule

// ===== rtl/hbcr_ramp.sv =====
// Color interpolation: multiply stage, then add and output register
`timescale 1ns / 1ps

module hbcr_ramp #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hbcr_pkg::tag_t         in_tag,
    input  logic [FRACTION_BITS:0] t,
    output logic                   out_valid,
    output hbcr_pkg::rgb_t         color
);

    localparam int F   = FRACTION_BITS;
    localparam int P_W = F + 11;

    hbcr_pkg::rgb_t       c_start;
    hbcr_pkg::rgb_t       c_end;
    logic signed [P_W-1:0] diff   [3];
    logic signed [P_W-1:0] prod   [3];
    logic signed [P_W-1:0] t_s;

    logic                  m_valid_reg;
    hbcr_pkg::rgb_t        m_start_reg;
    logic signed [P_W-1:0] m_prod_reg [3];

    always_comb
    begin
        c_start = hbcr_pkg::color_start(in_tag.cls);
        c_end   = hbcr_pkg::color_end(in_tag.cls);
        t_s     = {10'b0, t};
        for (int c = 0; c < 3; c++)
        begin
            diff[c] = P_W'($signed({1'b0, c_end[c]}) - $signed({1'b0, c_start[c]}));
            prod[c] = diff[c] * t_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            out_valid   <= 1'b0;
        end
        else
        begin
            m_valid_reg <= in_tag.valid;
            out_valid   <= m_valid_reg;
        end
    end

    // Floor of the scaled product is an arithmetic shift; the sum stays in 0..255
    always_ff @(posedge clk)
    begin
        m_start_reg <= c_start;
        for (int c = 0; c < 3; c++)
        begin
            m_prod_reg[c] <= prod[c];
            color[c]      <= m_start_reg[c] + m_prod_reg[c][F+7:F];
        end
    end

endmodule

// ===== rtl/height_band_color_ramp.sv =====
// Height band color ramp: top level, sea level register and pipeline
`timescale 1ns / 1ps
`include "height_band_color_ramp_macros.svh"

// From start to done a beat passes the classify stages, the divider stages (up to two
//   quotient bits each), and the ramp multiply and output registers.
// Throughput: one height sample per clock; busy never rises and done is a one-cycle strobe.
// Reset clears every valid bit in the pipeline and loads sea level 22938.
module height_band_color_ramp #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command channel
    input  logic                           start,
    output logic                           busy,
    input  logic signed [FRACTION_BITS+1:0] height,
    // result strobe
    output logic                           done,
    output logic [7:0]                     red,
    output logic [7:0]                     green,
    output logic [7:0]                     blue,
    // sea level write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [FRACTION_BITS:0]         shore_level
);

    localparam int F   = FRACTION_BITS;
    localparam int LAT = 4 + (F + 2) / 2;

    logic                  accept;
    logic [F:0]            shore_level_reg;

    hbcr_pkg::tag_t        cls_tag;
    logic [F:0]            cls_offset;
    logic [F:0]            cls_width;
    hbcr_pkg::tag_t        div_tag;
    logic [F:0]            div_t;
    hbcr_pkg::rgb_t        color;

    // The pipeline never stalls, so take a beat every cycle
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Hold the sea level; the user must write it only while the pipeline is empty, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shore_level_reg <= (F+1)'(hbcr_pkg::SEA_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            shore_level_reg <= shore_level;
        end
    end

    // Stage 1-2: classify the height and form offset and width within its band
    hbcr_classify #(
        .FRACTION_BITS (F)
    ) u_classify (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .height   (height),
        .sea      (shore_level_reg),
        .out_tag  (cls_tag),
        .offset   (cls_offset),
        .width    (cls_width)
    );

    // Divide offset by width into the Q1.F fraction t
    hbcr_div #(
        .FRACTION_BITS (F)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (cls_tag),
        .offset  (cls_offset),
        .width   (cls_width),
        .out_tag (div_tag),
        .t       (div_t)
    );

    // Interpolate each channel and register the result
    hbcr_ramp #(
        .FRACTION_BITS (F)
    ) u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (div_tag),
        .t         (div_t),
        .out_valid (done),
        .color     (color)
    );

    assign red   = color[hbcr_pkg::CH_RED];
    assign green = color[hbcr_pkg::CH_GREEN];
    assign blue  = color[hbcr_pkg::CH_BLUE];

    `HBCR_ASSERT_IMPLIES(a_done_latency, clk, rst_n, done, $past(accept, LAT), "done without matching start")
    `HBCR_ASSERT_NEXT(a_sea_write, clk, rst_n, cfg_valid && cfg_ready, shore_level_reg == $past(shore_level), "sea level write lost")

endmodule

// ===== tb/tb_height_band_color_ramp.sv =====
// Self-checking testbench for the height band color ramp
`timescale 1ns / 1ps

module tb_height_band_color_ramp;

    localparam int FRAC = 16;
    localparam longint ONE = longint'(1) << FRAC;
    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYCLES = 10;
    // Settle well past the pipeline latency before the verdict.
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_SETTING = 70;
    localparam int GAP_PCT = 27;

    // Ramp end points per class, indexed by band_t (ocean, then land bands 0..4).
    // Columns are red, green, blue.
    localparam int BRIGHT [6][3] = '{
        '{ 40,  95, 195},
        '{205, 185, 120},
        '{100, 178,  62},
        '{148, 132,  84},
        '{132, 122, 116},
        '{242, 242, 246}
    };
    localparam int DARK [6][3] = '{
        '{ 10,  30,  90},
        '{165, 148,  95},
        '{ 55, 120,  30},
        '{ 95,  85,  50},
        '{ 85,  78,  74},
        '{185, 183, 190}
    };
    localparam int PEAK_RGB [3] = '{242, 242, 246};

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic signed [FRAC+1:0] height = '0;
    logic                   cfg_valid = 1'b0;
    logic [FRAC:0]          shore_level = '0;
    logic                   busy;
    logic                   done;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic                   cfg_ready;

    // Heights waiting to be driven, and colors waiting to come out
    logic signed [FRAC+1:0] height_backlog [$];
    pixel_t                 color_queue [$];

    // Sea level as the block should currently hold it
    logic [FRAC:0] sea_model = (FRAC+1)'(hbcr_pkg::SEA_RESET);
    int gap_pct = GAP_PCT;
    int items_queued = 0;
    int items_accepted = 0;
    int colors_checked = 0;
    int sea_writes = 0;
    int fault_count = 0;
    int cycle_count = 0;

    height_band_color_ramp #(
        .FRACTION_BITS(FRAC)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .height     (height),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .shore_level(shore_level)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Upper end of land band k, rounded to the nearest fixed-point step
    function automatic longint band_top(int k);
        return (longint'(hbcr_pkg::END_HUND[k]) * ONE + 50) / 100;
    endfunction

    // Expected color for one height at a given sea level.
    // Classify first (ocean, a land band, or the flat peak color), then
    // ramp each channel from bright to dark by the fraction t.
    function automatic pixel_t ramp_color(logic signed [FRAC+1:0] h_in, logic [FRAC:0] sea_in);
        longint h;
        longint sea;
        longint lo;
        longint hi;
        longint t;
        longint num;
        longint ch [3];
        hbcr_pkg::band_t cls;
        int     k;
        pixel_t px;
        h = longint'(h_in);
        sea = longint'(sea_in);
        cls = hbcr_pkg::CLS_PEAK;
        lo = 0;
        hi = 0;
        if (h < sea) begin
            // Ocean ramps over 0..sea; negative heights clamp to t = 0 below
            cls = hbcr_pkg::CLS_OCEAN;
            hi = sea;
        end else begin
            // First band starts at the sea level, later ones at the previous end
            lo = sea;
            for (k = 0; k < hbcr_pkg::LAND_BANDS; k++) begin
                if (cls == hbcr_pkg::CLS_PEAK) begin
                    if (h <= band_top(k)) begin
                        cls = hbcr_pkg::band_t'(int'(hbcr_pkg::CLS_BAND0) + k);
                        hi = band_top(k);
                    end else begin
                        lo = band_top(k);
                    end
                end
            end
        end
        t = 0;
        if (hi - lo > 0 && h - lo > 0) begin
            t = ((h - lo) << FRAC) / (hi - lo);
            if (t > ONE)
                t = ONE;
        end
        for (k = 0; k < 3; k++) begin
            if (cls == hbcr_pkg::CLS_PEAK) begin
                ch[k] = PEAK_RGB[k];
            end else begin
                num = longint'(BRIGHT[int'(cls)][k]) * ONE
                    + longint'(DARK[int'(cls)][k] - BRIGHT[int'(cls)][k]) * t;
                if (num < 0)
                    num = 0;
                ch[k] = (num >>> FRAC) & 255;
            end
        end
        px.red = ch[0][7:0];
        px.green = ch[1][7:0];
        px.blue = ch[2][7:0];
        return px;
    endfunction

    // Random height: mostly near a boundary or in the useful range,
    // the rest anywhere in the full signed field so every bit toggles.
    function automatic logic signed [FRAC+1:0] pick_height(logic [FRAC:0] sea_in);
        longint v;
        int     mode;
        int     k;
        mode = $urandom_range(0, 99);
        if (mode < 40) begin
            k = $urandom_range(0, 6);
            if (k < hbcr_pkg::LAND_BANDS)
                v = band_top(k);
            else if (k == hbcr_pkg::LAND_BANDS)
                v = longint'(sea_in);
            else
                v = 0;
            v = v + longint'($urandom_range(0, 64)) - 32;
        end else if (mode < 80) begin
            v = longint'($urandom_range(0, 74096)) - 4096;
        end else begin
            v = longint'($urandom);
        end
        return v[FRAC+1:0];
    endfunction

    // Driver: hold the beat while busy, otherwise advance to the next
    // queued height or, at random, stay idle.
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) begin
                // Beat accepted at this edge: predict its color
                color_queue.push_back(ramp_color(height, sea_model));
                items_accepted++;
            end
            if (height_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                height <= height_backlog.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every done strobe carries one color; match it to the oldest prediction
    always @(posedge clk) begin
        pixel_t want;
        if (rst_n && done) begin
            if (color_queue.size() == 0) begin
                $error("unexpected color beat: red %0d green %0d blue %0d", red, green, blue);
                fault_count++;
            end else begin
                want = color_queue.pop_front();
                colors_checked++;
                if (red !== want.red) begin
                    $error("red mismatch: expected %0d, got %0d", want.red, red);
                    fault_count++;
                end
                if (green !== want.green) begin
                    $error("green mismatch: expected %0d, got %0d", want.green, green);
                    fault_count++;
                end
                if (blue !== want.blue) begin
                    $error("blue mismatch: expected %0d, got %0d", want.blue, blue);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog on the whole run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d colors still pending",
                     cycle_count, color_queue.size());
            $display("FAIL height_band_color_ramp");
            $finish;
        end
    end

    // Write the sea level through its own valid/ready channel; only called when idle
    task automatic write_sea(input logic [FRAC:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        shore_level <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sea_model = value;
        sea_writes++;
    endtask

    task automatic queue_height(input longint h);
        height_backlog.push_back(h[FRAC+1:0]);
        items_queued++;
    endtask

    // Wait until every queued height was taken and every color came back
    task automatic drain();
        while (items_accepted != items_queued || color_queue.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // One setting: program the sea level, probe around it, then random heights
    task automatic run_setting(input longint sea, input int pct);
        int n;
        write_sea(sea[FRAC:0]);
        gap_pct = pct;
        queue_height(longint'(sea[FRAC:0]) - 1);
        queue_height(longint'(sea[FRAC:0]));
        queue_height(longint'(sea[FRAC:0]) + 1);
        for (n = 0; n < RANDOM_PER_SETTING; n++)
            queue_height(longint'(pick_height(sea[FRAC:0])));
        drain();
    endtask

    initial begin
        int k;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats at the reset sea level: field extremes, the sea
        // boundary, each band end and one step past it, and the peak.
        queue_height(-(longint'(1) << (FRAC + 1)));
        queue_height((longint'(1) << (FRAC + 1)) - 1);
        queue_height(-ONE);
        queue_height(-1);
        queue_height(0);
        queue_height(1);
        queue_height(longint'(hbcr_pkg::SEA_RESET) - 1);
        queue_height(longint'(hbcr_pkg::SEA_RESET));
        queue_height(longint'(hbcr_pkg::SEA_RESET) + 1);
        for (k = 0; k < hbcr_pkg::LAND_BANDS; k++) begin
            queue_height(band_top(k));
            queue_height(band_top(k) + 1);
        end
        queue_height(ONE - 1);
        queue_height(100000);
        drain();

        // Sweep sea level settings: zero, one step, exactly a band end, above
        // the first band end, full scale, above full scale up to the register
        // maximum, then a few random values. Two settings run without gaps.
        run_setting(0, GAP_PCT);
        run_setting(1, GAP_PCT);
        run_setting(band_top(0), GAP_PCT);
        run_setting(40000, GAP_PCT);
        run_setting(ONE, 0);
        run_setting(ONE - 1, GAP_PCT);
        run_setting(100000, GAP_PCT);
        run_setting((longint'(1) << (FRAC + 1)) - 1, GAP_PCT);
        run_setting(longint'($urandom_range(0, (1 << (FRAC + 1)) - 1)), 0);
        run_setting(longint'($urandom_range(0, int'(ONE))), GAP_PCT);
        run_setting(longint'(hbcr_pkg::SEA_RESET), GAP_PCT);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (color_queue.size() != 0) begin
            $error("%0d predicted colors never came out", color_queue.size());
            fault_count++;
        end

        $display("Drove %0d height beats across %0d sea level writes; %0d colors compared.",
                 items_accepted, sea_writes, colors_checked);
        $display("Covered ocean, all five land bands, the peak color and sea levels 0 to max.");
        if (fault_count == 0) begin
            $display("PASS height_band_color_ramp");
        end else begin
            $display("FAIL height_band_color_ramp");
        end
        $finish;
    end

endmodule
